FILE: hw/rtl/multilevel_feedback_scheduler_core_assert.svh
// assertion macros for the multilevel feedback scheduler
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_CORE_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MFS_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
`define MFS_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define MFS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MFS_ASSERT(lbl, expr, msg)
`define MFS_IMPLY(lbl, ante, cons, msg)
`define MFS_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/mlfq_pkg.sv
// types and constants of the multilevel feedback scheduler
package mlfq_pkg;

  typedef enum logic [1:0] {
    OP_ADMIT         = 2'd0,
    OP_BURST_DONE    = 2'd1,
    OP_SLICE_EXPIRED = 2'd2,
    OP_IO_DONE       = 2'd3
  } op_e;

  localparam logic [2:0] REG_LEVELS = 3'd0;
  localparam logic [2:0] REG_SLICE0 = 3'd1;
  localparam logic [2:0] REG_SLICE1 = 3'd2;
  localparam logic [2:0] REG_SLICE2 = 3'd3;
  localparam logic [2:0] REG_SLICE3 = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] event_time;
    logic [3:0]  proc_id;
    logic [15:0] burst_length;
    logic [1:0]  start_level;
  } in_t;

  typedef struct packed {
    logic        dispatched;
    logic [3:0]  run_pid;
    logic [31:0] run_until;
    logic        run_kind;
    logic        cpu_busy;
    logic        preempted;
    logic [3:0]  preempted_pid;
    logic [3:0]  blocked_pid;
    logic [1:0]  moved_level;
  } out_t;

  typedef struct packed {
    op_e         op;
    logic        pid_ok;
    logic        burst_nz;
    logic [31:0] event_time;
    logic [3:0]  proc_id;
    logic [15:0] burst_length;
    logic [1:0]  start_level;
  } cmd_t;

  typedef struct packed {
    logic [2:0]       levels_in_use;
    logic [3:0][15:0] slice;
  } cfg_t;

endpackage

FILE: hw/rtl/mlfq_fifo.sv
// small register fifo
module mlfq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [NW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == NW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule

FILE: hw/rtl/mlfq_front.sv
// event intake: decodes events and queues them for the scheduling engine
module mlfq_front #(
  parameter int MAX_PROCS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mlfq_pkg::in_t  in_data_i,
  output logic           full_o,
  output logic           cmd_valid_o,
  output mlfq_pkg::cmd_t cmd_o,
  input  logic           cmd_pop_i
);
  mlfq_pkg::cmd_t cmd_in;
  logic [$bits(mlfq_pkg::cmd_t)-1:0] cmd_raw;
  logic cmd_empty;

  always_comb begin
    cmd_in.op           = mlfq_pkg::op_e'(in_data_i.opcode);
    cmd_in.pid_ok       = (32'(in_data_i.proc_id) < MAX_PROCS);
    cmd_in.burst_nz     = (in_data_i.burst_length != '0);
    cmd_in.event_time   = in_data_i.event_time;
    cmd_in.proc_id      = in_data_i.proc_id;
    cmd_in.burst_length = in_data_i.burst_length;
    cmd_in.start_level  = in_data_i.start_level;
  end

  mlfq_fifo #(
    .WIDTH($bits(mlfq_pkg::cmd_t)),
    .DEPTH(2)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (cmd_in),
    .full_o (full_o),
    .pop_i  (cmd_pop_i),
    .data_o (cmd_raw),
    .empty_o(cmd_empty)
  );

  assign cmd_o       = mlfq_pkg::cmd_t'(cmd_raw);
  assign cmd_valid_o = !cmd_empty;
endmodule

FILE: hw/rtl/mlfq_back.sv
// scheduling engine: level queues, process tables, runner and result queue
`include "multilevel_feedback_scheduler_core_assert.svh"
module mlfq_back #(
  parameter int NUM_LEVELS = 4,
  parameter int MAX_PROCS  = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  mlfq_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  mlfq_pkg::cfg_t cfg_i,
  input  logic           pop_i,
  output logic           empty_o,
  output mlfq_pkg::out_t out_data_o
);
  localparam int LW  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int PW  = $clog2(MAX_PROCS);
  localparam int CW  = PW + 1;
  localparam int QAW = $clog2(NUM_LEVELS * MAX_PROCS);
  localparam int QD  = NUM_LEVELS * MAX_PROCS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EV   = 4'd1;
  localparam logic [3:0] S_EV2  = 4'd2;
  localparam logic [3:0] S_SCH  = 4'd3;
  localparam logic [3:0] S_PR   = 4'd4;
  localparam logic [3:0] S_D1   = 4'd5;
  localparam logic [3:0] S_D2   = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;

  logic [3:0] state_q, state_d;
  mlfq_pkg::cmd_t cmd_q;

  logic [3:0]  qmem [QD];
  logic [15:0] rem_mem [MAX_PROCS];
  logic [LW-1:0] lv_mem [MAX_PROCS];
  logic [3:0]  q_rd;
  logic [15:0] rem_rd;
  logic [LW-1:0] lv_rd;

  logic [PW-1:0] head_q [NUM_LEVELS];
  logic [CW-1:0] cnt_q  [NUM_LEVELS];

  logic        rv_q;
  logic [3:0]  rid_q;
  logic [31:0] rstart_q, rend_q;
  logic        rkind_q;
  logic        disp_q, pre_q;
  logic [3:0]  prepid_q, blk_q;
  logic [LW-1:0] moved_q, best_q;

  logic [LW-1:0] top_lvl, best, rd_lvl;
  logic          found;
  logic [QAW-1:0] q_raddr, q_waddr;
  logic [PW-1:0] lv_raddr, rem_raddr, lv_waddr, rem_waddr, rix, cix;
  logic          lv_we, rem_we;
  logic [LW-1:0] lv_wdata;
  logic [15:0]   rem_wdata;
  logic          enq_en, enq_ok, pop_en;
  logic [LW-1:0] enq_lvl;
  logic [3:0]    enq_pid;
  logic [PW:0]   enq_sum;
  logic [PW-1:0] enq_idx;
  logic          out_push, out_full;
  mlfq_pkg::out_t out_d;
  logic [$bits(mlfq_pkg::out_t)-1:0] out_raw;
  logic [15:0]   sl_ev2, sl_d2, sat_slice, sat_elapsed;
  logic [31:0]   elapsed;
  logic [LW-1:0] dec_lvl, up_lvl, io_lvl, start_lvl;

  function automatic logic [LW-1:0] clamp(input logic [3:0] x, input logic [LW-1:0] t);
    return (x > 4'(t)) ? t : LW'(x);
  endfunction

  function automatic logic [15:0] slice_of(input logic [LW-1:0] l, input mlfq_pkg::cfg_t c);
    logic [1:0]  i;
    logic [15:0] s;
    i = (32'(l) < 4) ? 2'(l) : 2'd3;
    s = c.slice[i];
    return (s == '0) ? 16'd1 : s;
  endfunction

  function automatic logic [QAW-1:0] qaddr(input logic [LW-1:0] l, input logic [PW-1:0] i);
    return QAW'(QAW'(l) * QAW'(MAX_PROCS) + QAW'(i));
  endfunction

  always_comb begin
    if (cfg_i.levels_in_use == '0) begin
      top_lvl = '0;
    end else if (32'(cfg_i.levels_in_use) > NUM_LEVELS) begin
      top_lvl = LW'(NUM_LEVELS - 1);
    end else begin
      top_lvl = LW'(cfg_i.levels_in_use - 3'd1);
    end
  end

  always_comb begin
    best  = '0;
    found = 1'b0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (cnt_q[i] != '0) begin
        best  = LW'(i);
        found = 1'b1;
      end
    end
  end

  assign rix       = PW'(rid_q);
  assign cix       = PW'(cmd_q.proc_id);
  assign sl_ev2    = slice_of(lv_rd, cfg_i);
  assign sl_d2     = slice_of(best_q, cfg_i);
  assign sat_slice = (rem_rd > sl_ev2) ? rem_rd - sl_ev2 : '0;
  assign elapsed   = cmd_q.event_time - rstart_q;
  assign sat_elapsed = (32'(rem_rd) > elapsed) ? rem_rd - elapsed[15:0] : '0;
  assign dec_lvl   = (lv_rd != '0) ? lv_rd - 1'b1 : '0;
  assign up_lvl    = clamp(4'(lv_rd) + 4'd1, top_lvl);
  assign io_lvl    = clamp(4'(lv_rd), top_lvl);
  assign start_lvl = clamp(4'(cmd_q.start_level), top_lvl);

  assign rd_lvl    = (state_q == S_SCH) ? best : best_q;
  assign q_raddr   = qaddr(rd_lvl, head_q[rd_lvl]);
  assign lv_raddr  = (state_q == S_EV && cmd_q.op == mlfq_pkg::OP_IO_DONE) ? cix : rix;
  assign rem_raddr = (state_q == S_D1) ? PW'(q_rd) : rix;

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    lv_we     = 1'b0;
    lv_waddr  = rix;
    lv_wdata  = lv_rd;
    rem_we    = 1'b0;
    rem_waddr = rix;
    rem_wdata = '0;
    enq_en    = 1'b0;
    enq_lvl   = lv_rd;
    enq_pid   = rid_q;
    pop_en    = 1'b0;
    out_push  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          state_d   = S_EV;
        end
      end
      S_EV: begin
        state_d = S_SCH;
        unique case (cmd_q.op)
          mlfq_pkg::OP_ADMIT: begin
            if (cmd_q.pid_ok) begin
              rem_we    = 1'b1;
              rem_waddr = cix;
              rem_wdata = cmd_q.burst_length;
              lv_we     = 1'b1;
              lv_waddr  = cix;
              lv_wdata  = start_lvl;
              enq_en    = 1'b1;
              enq_lvl   = start_lvl;
              enq_pid   = cmd_q.proc_id;
            end
          end
          mlfq_pkg::OP_BURST_DONE, mlfq_pkg::OP_SLICE_EXPIRED: begin
            if (rv_q) begin
              state_d = S_EV2;
            end
          end
          mlfq_pkg::OP_IO_DONE: begin
            if (cmd_q.pid_ok && cmd_q.burst_nz) begin
              state_d = S_EV2;
            end
          end
          default: ;
        endcase
      end
      S_EV2: begin
        state_d = S_SCH;
        unique case (cmd_q.op)
          mlfq_pkg::OP_BURST_DONE: begin
            lv_we    = 1'b1;
            lv_wdata = dec_lvl;
            rem_we   = 1'b1;
          end
          mlfq_pkg::OP_SLICE_EXPIRED: begin
            lv_we     = 1'b1;
            lv_wdata  = up_lvl;
            rem_we    = 1'b1;
            rem_wdata = sat_slice;
            enq_en    = 1'b1;
            enq_lvl   = up_lvl;
          end
          mlfq_pkg::OP_IO_DONE: begin
            lv_we     = 1'b1;
            lv_waddr  = cix;
            lv_wdata  = io_lvl;
            rem_we    = 1'b1;
            rem_waddr = cix;
            rem_wdata = cmd_q.burst_length;
            enq_en    = 1'b1;
            enq_lvl   = io_lvl;
            enq_pid   = cmd_q.proc_id;
          end
          default: ;
        endcase
      end
      S_SCH: begin
        if (!found) begin
          state_d = S_OUT;
        end else if (!rv_q) begin
          state_d = S_D1;
        end else begin
          state_d = S_PR;
        end
      end
      S_PR: begin
        if (best_q < lv_rd) begin
          rem_we    = 1'b1;
          rem_wdata = sat_elapsed;
          enq_en    = 1'b1;
          enq_lvl   = lv_rd;
          state_d   = S_D1;
        end else begin
          state_d = S_OUT;
        end
      end
      S_D1: begin
        pop_en   = 1'b1;
        lv_we    = 1'b1;
        lv_waddr = PW'(q_rd);
        lv_wdata = best_q;
        state_d  = S_D2;
      end
      S_D2: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_full) begin
          out_push = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign enq_ok  = enq_en && (cnt_q[enq_lvl] < CW'(MAX_PROCS));
  assign enq_sum = (PW + 1)'(head_q[enq_lvl]) + cnt_q[enq_lvl];
  assign enq_idx = (enq_sum >= (PW + 1)'(MAX_PROCS)) ?
                   PW'(enq_sum - (PW + 1)'(MAX_PROCS)) : PW'(enq_sum);
  assign q_waddr = qaddr(enq_lvl, enq_idx);

  always_ff @(posedge clk_i) begin
    if (enq_ok) begin
      qmem[q_waddr] <= enq_pid;
    end
    q_rd <= qmem[q_raddr];
    if (rem_we) begin
      rem_mem[rem_waddr] <= rem_wdata;
    end
    rem_rd <= rem_mem[rem_raddr];
    if (lv_we) begin
      lv_mem[lv_waddr] <= lv_wdata;
    end
    lv_rd <= lv_mem[lv_raddr];
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (state_q == S_SCH) begin
      best_q <= best;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      rv_q     <= 1'b0;
      rid_q    <= '0;
      rstart_q <= '0;
      rend_q   <= '0;
      rkind_q  <= 1'b0;
      disp_q   <= 1'b0;
      pre_q    <= 1'b0;
      prepid_q <= '0;
      blk_q    <= '0;
      moved_q  <= '0;
    end else begin
      state_q <= state_d;
      if (enq_ok) begin
        cnt_q[enq_lvl] <= cnt_q[enq_lvl] + 1'b1;
      end
      if (pop_en) begin
        head_q[best_q] <= (head_q[best_q] == PW'(MAX_PROCS - 1)) ? '0 : head_q[best_q] + 1'b1;
        cnt_q[best_q]  <= cnt_q[best_q] - 1'b1;
      end
      if (cmd_pop_o) begin
        disp_q   <= 1'b0;
        pre_q    <= 1'b0;
        prepid_q <= '0;
        blk_q    <= '0;
        moved_q  <= '0;
      end
      if (state_q == S_EV2) begin
        if (cmd_q.op == mlfq_pkg::OP_BURST_DONE) begin
          rv_q    <= 1'b0;
          blk_q   <= rid_q;
          moved_q <= dec_lvl;
        end else if (cmd_q.op == mlfq_pkg::OP_SLICE_EXPIRED) begin
          rv_q    <= 1'b0;
          moved_q <= up_lvl;
        end
      end
      if (state_q == S_PR && best_q < lv_rd) begin
        pre_q    <= 1'b1;
        prepid_q <= rid_q;
      end
      if (state_q == S_D1) begin
        rid_q <= q_rd;
      end
      if (state_q == S_D2) begin
        rv_q     <= 1'b1;
        disp_q   <= 1'b1;
        rstart_q <= cmd_q.event_time;
        if (rem_rd <= sl_d2) begin
          rend_q  <= cmd_q.event_time + 32'(rem_rd);
          rkind_q <= 1'b0;
        end else begin
          rend_q  <= cmd_q.event_time + 32'(sl_d2);
          rkind_q <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_d.dispatched    = disp_q;
    out_d.run_pid       = rv_q ? rid_q : '0;
    out_d.run_until     = rv_q ? rend_q : '0;
    out_d.run_kind      = rv_q ? rkind_q : 1'b0;
    out_d.cpu_busy      = rv_q;
    out_d.preempted     = pre_q;
    out_d.preempted_pid = prepid_q;
    out_d.blocked_pid   = blk_q;
    out_d.moved_level   = 2'(moved_q);
  end

  mlfq_fifo #(
    .WIDTH($bits(mlfq_pkg::out_t)),
    .DEPTH(2)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (out_d),
    .full_o (out_full),
    .pop_i  (pop_i),
    .data_o (out_raw),
    .empty_o(empty_o)
  );

  assign out_data_o = mlfq_pkg::out_t'(out_raw);

  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_cnt_chk
    `MFS_ASSERT(a_cnt_bound, cnt_q[g] <= CW'(MAX_PROCS), "level queue count overflow")
  end
  `MFS_IMPLY(a_push_in_out, out_push, state_q == S_OUT && !out_full, "result transfer outside output step")
  `MFS_NEXT(a_dispatch_busy, state_q == S_D2, rv_q && disp_q, "dispatch did not start runner")
  `MFS_IMPLY(a_pop_no_enq, pop_en, !enq_en, "dequeue and enqueue in one cycle")
endmodule

FILE: hw/rtl/multilevel_feedback_scheduler_core.sv
// top level of the multilevel feedback scheduler
// each event passes the engine sequencer steps for queue and process table read-modify-write
// from intake transfer to result; a new event is taken only once the result is queued
// two-entry queues at intake and result sides let both sides stall independently
// reset is asynchronous active low: queues empty, cpu idle, registers to defaults
module multilevel_feedback_scheduler_core #(
  parameter int NUM_LEVELS = 4,
  parameter int MAX_PROCS  = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  input  mlfq_pkg::in_t  in_data_i,
  output logic           full,
  output logic           empty,
  input  logic           pop,
  output mlfq_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [15:0]    cfg_data_i
);
  mlfq_pkg::cfg_t cfg_q;
  mlfq_pkg::cmd_t cmd;
  logic cmd_valid, cmd_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.levels_in_use <= 3'd4;
      cfg_q.slice[0]      <= 16'd4;
      cfg_q.slice[1]      <= 16'd8;
      cfg_q.slice[2]      <= 16'd16;
      cfg_q.slice[3]      <= 16'd32;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mlfq_pkg::REG_LEVELS: cfg_q.levels_in_use <= cfg_data_i[2:0];
        mlfq_pkg::REG_SLICE0: cfg_q.slice[0] <= cfg_data_i;
        mlfq_pkg::REG_SLICE1: cfg_q.slice[1] <= cfg_data_i;
        mlfq_pkg::REG_SLICE2: cfg_q.slice[2] <= cfg_data_i;
        mlfq_pkg::REG_SLICE3: cfg_q.slice[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mlfq_front #(
    .MAX_PROCS(MAX_PROCS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_data_i  (in_data_i),
    .full_o     (full),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  mlfq_back #(
    .NUM_LEVELS(NUM_LEVELS),
    .MAX_PROCS (MAX_PROCS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .cfg_i      (cfg_q),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_data_o (out_data_o)
  );
endmodule
